[hdl/wssm_pkg.sv]
// Shared types and constants for the weighted sorted stream merge.
// Holds the controller state encoding and the command and status bundles.
// No dependencies.
`timescale 1ns / 1ps

package wssm_pkg;

   localparam int WORD_BITS     = 31;
   localparam int SRC_BITS      = 3;
   localparam int WEIGHT_BITS   = 24;
   localparam int USED_BITS     = 4;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 24;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_BITS-1:0] CSR_WEIGHT          = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WEIGHTED_SOURCE = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SOURCES_USED    = 2'd2;

   localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = 24'd65536;
   localparam logic [SRC_BITS-1:0]    WSRC_RESET   = 3'd1;
   localparam logic [USED_BITS-1:0]   USED_RESET   = 4'd2;

   typedef enum logic [12:0] {
      S_IDLE    = 13'h0001,
      S_DECIDE  = 13'h0002,
      S_MUL_HI  = 13'h0004,
      S_MUL_LO  = 13'h0008,
      S_SCALE   = 13'h0010,
      S_INSERT  = 13'h0020,
      S_ADVANCE = 13'h0040,
      S_RD      = 13'h0080,
      S_CMP     = 13'h0100,
      S_POP     = 13'h0200,
      S_MV_RD   = 13'h0400,
      S_MV_WR   = 13'h0800,
      S_RESULT  = 13'h1000
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic ignore;
      logic mul_hi;
      logic mul_lo;
      logic scale;
      logic insert;
      logic advance;
      logic load_res;
      logic flush;
      logic rd_scan;
      logic scan;
      logic pop;
      logic rd_move;
      logic wr_move;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic done;
      logic match;
      logic insert_ok;
      logic weighted;
      logic waiting;
      logic load_last;
      logic live_zero;
      logic scan_more;
      logic move_needed;
      logic out_free;
   } dp_status_type;

endpackage

[hdl/wssm_req_if.sv]
// Input record channel with valid/ready handshake.
// Depends on wssm_pkg for field widths.
`timescale 1ns / 1ps

interface wssm_req_if #(
   parameter int VALUE_BITS = 48
);
   logic                               valid;
   logic                               ready;
   logic [wssm_pkg::WORD_BITS-1:0]     first_word;
   logic [wssm_pkg::WORD_BITS-1:0]     second_word;
   logic [VALUE_BITS-1:0]              count_value;
   logic [wssm_pkg::SRC_BITS-1:0]      source;
   logic                               source_ended;

   modport source_mp (output valid, first_word, second_word, count_value, source,
                      source_ended, input ready);
   modport sink (input valid, first_word, second_word, count_value, source,
                 source_ended, output ready);
endinterface

[hdl/wssm_rsp_if.sv]
// Result channel with valid/ready handshake.
// Depends on wssm_pkg for field widths.
`timescale 1ns / 1ps

interface wssm_rsp_if #(
   parameter int VALUE_BITS = 48
);
   logic                               valid;
   logic                               ready;
   logic                               emit;
   logic [wssm_pkg::WORD_BITS-1:0]     out_first_word;
   logic [wssm_pkg::WORD_BITS-1:0]     out_second_word;
   logic [VALUE_BITS-1:0]              out_value;
   logic [wssm_pkg::SRC_BITS-1:0]      next_source;
   logic                               merge_done;

   modport source_mp (output valid, emit, out_first_word, out_second_word, out_value,
                      next_source, merge_done, input ready);
   modport sink (input valid, emit, out_first_word, out_second_word, out_value,
                 next_source, merge_done, output ready);
endinterface

[hdl/wssm_csr_if.sv]
// Configuration write channel: register index and write data.
// Depends on wssm_pkg for field widths.
`timescale 1ns / 1ps

interface wssm_csr_if;
   logic                                valid;
   logic                                ready;
   logic [wssm_pkg::CSR_IDX_BITS-1:0]   index;
   logic [wssm_pkg::CSR_DATA_BITS-1:0]  data;

   modport source_mp (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[hdl/wssm_ctrl.sv]
// Controller state machine of the merge: sequences one input item through
// decode, scaling, insertion, head scan, pop and result. Depends on wssm_pkg.
`timescale 1ns / 1ps

module wssm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  wssm_pkg::dp_status_type status,
   output wssm_pkg::dp_cmd_type    cmd
);

   wssm_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wssm_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         wssm_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = wssm_pkg::S_DECIDE;
            end
         end
         wssm_pkg::S_DECIDE: begin
            if (status.done || !status.match) begin
               cmd.ignore = 1'b1;
               state_in   = wssm_pkg::S_RESULT;
            end else if (status.insert_ok && status.weighted) begin
               state_in = wssm_pkg::S_MUL_HI;
            end else if (status.insert_ok) begin
               state_in = wssm_pkg::S_INSERT;
            end else begin
               state_in = wssm_pkg::S_ADVANCE;
            end
         end
         wssm_pkg::S_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = wssm_pkg::S_MUL_LO;
         end
         wssm_pkg::S_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = wssm_pkg::S_SCALE;
         end
         wssm_pkg::S_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = wssm_pkg::S_INSERT;
         end
         wssm_pkg::S_INSERT: begin
            cmd.insert = 1'b1;
            state_in   = wssm_pkg::S_ADVANCE;
         end
         wssm_pkg::S_ADVANCE: begin
            cmd.advance = 1'b1;
            if (!status.waiting && !status.load_last) begin
               cmd.load_res = 1'b1;
               state_in     = wssm_pkg::S_RESULT;
            end else if (status.live_zero) begin
               cmd.flush = 1'b1;
               state_in  = wssm_pkg::S_RESULT;
            end else begin
               state_in = wssm_pkg::S_RD;
            end
         end
         wssm_pkg::S_RD: begin
            cmd.rd_scan = 1'b1;
            state_in    = wssm_pkg::S_CMP;
         end
         wssm_pkg::S_CMP: begin
            cmd.scan = 1'b1;
            state_in = status.scan_more ? wssm_pkg::S_RD : wssm_pkg::S_POP;
         end
         wssm_pkg::S_POP: begin
            cmd.pop  = 1'b1;
            state_in = status.move_needed ? wssm_pkg::S_MV_RD : wssm_pkg::S_RESULT;
         end
         wssm_pkg::S_MV_RD: begin
            cmd.rd_move = 1'b1;
            state_in    = wssm_pkg::S_MV_WR;
         end
         wssm_pkg::S_MV_WR: begin
            cmd.wr_move = 1'b1;
            state_in    = wssm_pkg::S_RESULT;
         end
         wssm_pkg::S_RESULT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = wssm_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = wssm_pkg::S_IDLE;
         end
      endcase
   end

endmodule

[hdl/wssm_datapath.sv]
// Datapath of the merge: configuration registers, head slot memory, weight
// multiplier, accumulator and result register. Depends on wssm_pkg.
`timescale 1ns / 1ps

module wssm_datapath #(
   parameter int SOURCES    = 2,
   parameter int VALUE_BITS = 48
) (
   input  logic                                clock,
   input  logic                                reset,
   input  wssm_pkg::dp_cmd_type                cmd,
   output wssm_pkg::dp_status_type             status,
   // input record
   input  logic [wssm_pkg::WORD_BITS-1:0]      in_first_word,
   input  logic [wssm_pkg::WORD_BITS-1:0]      in_second_word,
   input  logic [VALUE_BITS-1:0]               in_count_value,
   input  logic [wssm_pkg::SRC_BITS-1:0]       in_source,
   input  logic                                in_source_ended,
   // configuration writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [wssm_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [wssm_pkg::CSR_DATA_BITS-1:0]  csr_data,
   // result
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_emit,
   output logic [wssm_pkg::WORD_BITS-1:0]      rsp_first_word,
   output logic [wssm_pkg::WORD_BITS-1:0]      rsp_second_word,
   output logic [VALUE_BITS-1:0]               rsp_value,
   output logic [wssm_pkg::SRC_BITS-1:0]       rsp_next_source,
   output logic                                rsp_merge_done
);

   localparam int WB = wssm_pkg::WORD_BITS;
   localparam int SB = wssm_pkg::SRC_BITS;
   localparam int CW = $clog2(SOURCES + 1);
   localparam int AW = $clog2(SOURCES);
   localparam int EW = 2 * WB + VALUE_BITS + SB;
   localparam int PW = 32 + wssm_pkg::WEIGHT_BITS;

   localparam logic [VALUE_BITS-1:0] VMAX   = {VALUE_BITS{1'b1}};
   localparam logic [64:0]           VMAX65 = 65'(VMAX);

   // configuration
   logic [wssm_pkg::WEIGHT_BITS-1:0] weight_ff;
   logic [SB-1:0]                    wsrc_ff;
   logic [wssm_pkg::USED_BITS-1:0]   used_ff;

   // captured input item
   logic [WB-1:0]         in_fw_ff, in_sw_ff;
   logic [VALUE_BITS-1:0] in_val_ff;
   logic [SB-1:0]         in_src_ff;
   logic                  in_end_ff;

   // merge control state
   logic [CW-1:0] n_ff, load_ff, live_ff;
   logic          waiting_ff, done_ff;
   logic [SB-1:0] pend_ff;

   // accumulator
   logic [WB-1:0]         acc_fw_ff, acc_sw_ff;
   logic [VALUE_BITS-1:0] acc_val_ff;
   logic                  acc_valid_ff;

   // scaling
   logic [PW-1:0]         ph_ff, pl_ff;
   logic [VALUE_BITS-1:0] ins_val_ff;

   // head slots and scan
   logic [EW-1:0]         slot_mem [SOURCES];
   logic [EW-1:0]         rd_ff;
   logic [AW-1:0]         idx_ff, best_slot_ff;
   logic [WB-1:0]         best_fw_ff, best_sw_ff;
   logic [VALUE_BITS-1:0] best_val_ff;
   logic [SB-1:0]         best_ord_ff;

   // staged result
   logic                  res_emit_ff, res_done_ff;
   logic [WB-1:0]         res_fw_ff, res_sw_ff;
   logic [VALUE_BITS-1:0] res_val_ff;
   logic [SB-1:0]         res_next_ff;

   // output register
   logic                  out_valid_ff, out_emit_ff, out_done_ff;
   logic [WB-1:0]         out_fw_ff, out_sw_ff;
   logic [VALUE_BITS-1:0] out_val_ff;
   logic [SB-1:0]         out_next_ff;

   logic [SB-1:0]         expected;
   logic [63:0]           v64;
   logic [63:0]           hi64;
   logic [64:0]           sum65;
   logic [VALUE_BITS-1:0] scaled;
   logic [WB-1:0]         rd_fw, rd_sw;
   logic [VALUE_BITS-1:0] rd_val;
   logic [SB-1:0]         rd_ord;
   logic                  rd_before;
   logic [AW-1:0]         rd_addr;
   logic [VALUE_BITS:0]   acc_sum;
   logic [VALUE_BITS-1:0] acc_sat;
   logic                  key_hit;
   logic [CW-1:0]         n_sample;

   assign csr_ready = 1'b1;

   assign expected = waiting_ff ? pend_ff : SB'(load_ff);
   assign v64      = 64'(in_val_ff);
   assign {rd_fw, rd_sw, rd_val, rd_ord} = rd_ff;

   // The product was split at bit 32 of the value; recombine and saturate.
   assign hi64   = {ph_ff[47:0], 16'b0};
   assign sum65  = {1'b0, hi64} + 65'(pl_ff[PW-1:16]);
   assign scaled = ((ph_ff[PW-1:48] != '0) || (sum65 > VMAX65)) ? VMAX
                                                                 : VALUE_BITS'(sum65);

   // Ties on the key go to the lower source index.
   always_comb begin
      if (rd_fw != best_fw_ff) begin
         rd_before = rd_fw < best_fw_ff;
      end else if (rd_sw != best_sw_ff) begin
         rd_before = rd_sw < best_sw_ff;
      end else begin
         rd_before = rd_ord < best_ord_ff;
      end
   end

   assign rd_addr = cmd.rd_move ? live_ff[AW-1:0] : idx_ff;
   assign acc_sum = {1'b0, acc_val_ff} + {1'b0, best_val_ff};
   assign acc_sat = acc_sum[VALUE_BITS] ? VMAX : acc_sum[VALUE_BITS-1:0];
   assign key_hit = acc_valid_ff && (acc_fw_ff == best_fw_ff) && (acc_sw_ff == best_sw_ff);

   always_comb begin
      if (used_ff == '0) begin
         n_sample = CW'(1);
      end else if ({1'b0, used_ff} > (wssm_pkg::USED_BITS + 1)'(SOURCES)) begin
         n_sample = CW'(SOURCES);
      end else begin
         n_sample = CW'(used_ff);
      end
   end

   always_comb begin
      status             = '0;
      status.done        = done_ff;
      status.match       = in_src_ff == expected;
      status.insert_ok   = !in_end_ff && (live_ff < CW'(SOURCES));
      status.weighted    = in_src_ff == wsrc_ff;
      status.waiting     = waiting_ff;
      status.load_last   = (load_ff + CW'(1)) >= n_ff;
      status.live_zero   = live_ff == '0;
      status.scan_more   = (CW'(idx_ff) + CW'(1)) < live_ff;
      status.move_needed = CW'(best_slot_ff) != (live_ff - CW'(1));
      status.out_free    = !out_valid_ff || rsp_ready;
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= wssm_pkg::WEIGHT_RESET;
         wsrc_ff   <= wssm_pkg::WSRC_RESET;
         used_ff   <= wssm_pkg::USED_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            wssm_pkg::CSR_WEIGHT:          weight_ff <= csr_data;
            wssm_pkg::CSR_WEIGHTED_SOURCE: wsrc_ff   <= csr_data[SB-1:0];
            wssm_pkg::CSR_SOURCES_USED:    used_ff   <= csr_data[wssm_pkg::USED_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Head slot memory, one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         slot_mem[live_ff[AW-1:0]] <= {in_fw_ff, in_sw_ff,
                                       status.weighted ? ins_val_ff : in_val_ff, in_src_ff};
      end else if (cmd.wr_move) begin
         slot_mem[best_slot_ff] <= rd_ff;
      end
      rd_ff <= slot_mem[rd_addr];
   end

   // Payload registers without reset.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         in_fw_ff  <= in_first_word;
         in_sw_ff  <= in_second_word;
         in_val_ff <= in_count_value;
         in_src_ff <= in_source;
         in_end_ff <= in_source_ended;
      end
      if (cmd.mul_hi) begin
         ph_ff <= PW'(v64[63:32]) * PW'(weight_ff);
      end
      if (cmd.mul_lo) begin
         pl_ff <= PW'(v64[31:0]) * PW'(weight_ff);
      end
      if (cmd.scale) begin
         ins_val_ff <= scaled;
      end
      if (cmd.scan && ((idx_ff == '0) || rd_before)) begin
         best_fw_ff   <= rd_fw;
         best_sw_ff   <= rd_sw;
         best_val_ff  <= rd_val;
         best_ord_ff  <= rd_ord;
         best_slot_ff <= idx_ff;
      end
      if (cmd.advance) begin
         idx_ff <= '0;
      end else if (cmd.scan && status.scan_more) begin
         idx_ff <= idx_ff + AW'(1);
      end
      if (cmd.ignore) begin
         res_emit_ff <= 1'b0;
         res_fw_ff   <= '0;
         res_sw_ff   <= '0;
         res_val_ff  <= '0;
         res_next_ff <= done_ff ? '0 : expected;
         res_done_ff <= done_ff;
      end else if (cmd.load_res) begin
         res_emit_ff <= 1'b0;
         res_fw_ff   <= '0;
         res_sw_ff   <= '0;
         res_val_ff  <= '0;
         res_next_ff <= SB'(load_ff + CW'(1));
         res_done_ff <= 1'b0;
      end else if (cmd.flush) begin
         res_emit_ff <= acc_valid_ff;
         res_fw_ff   <= acc_valid_ff ? acc_fw_ff : '0;
         res_sw_ff   <= acc_valid_ff ? acc_sw_ff : '0;
         res_val_ff  <= acc_valid_ff ? acc_val_ff : '0;
         res_next_ff <= '0;
         res_done_ff <= 1'b1;
      end else if (cmd.pop) begin
         res_emit_ff <= !key_hit && acc_valid_ff;
         res_fw_ff   <= (!key_hit && acc_valid_ff) ? acc_fw_ff : '0;
         res_sw_ff   <= (!key_hit && acc_valid_ff) ? acc_sw_ff : '0;
         res_val_ff  <= (!key_hit && acc_valid_ff) ? acc_val_ff : '0;
         res_next_ff <= best_ord_ff;
         res_done_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         out_emit_ff <= res_emit_ff;
         out_fw_ff   <= res_fw_ff;
         out_sw_ff   <= res_sw_ff;
         out_val_ff  <= res_val_ff;
         out_next_ff <= res_next_ff;
         out_done_ff <= res_done_ff;
      end
   end

   // Merge control state and accumulator.
   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff         <= CW'(1);
         load_ff      <= '0;
         live_ff      <= '0;
         waiting_ff   <= 1'b0;
         done_ff      <= 1'b0;
         pend_ff      <= '0;
         acc_fw_ff    <= '0;
         acc_sw_ff    <= '0;
         acc_val_ff   <= '0;
         acc_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         // The source count is sampled until the first item is taken.
         if (cmd.capture && !done_ff && !waiting_ff && (load_ff == '0)) begin
            n_ff <= n_sample;
         end
         if (cmd.insert) begin
            live_ff <= live_ff + CW'(1);
         end else if (cmd.pop) begin
            live_ff <= live_ff - CW'(1);
         end
         if (cmd.advance) begin
            if (!waiting_ff) begin
               load_ff <= load_ff + CW'(1);
            end
            waiting_ff <= 1'b0;
         end else if (cmd.pop) begin
            waiting_ff <= 1'b1;
         end
         if (cmd.pop) begin
            pend_ff <= best_ord_ff;
            if (key_hit) begin
               acc_val_ff <= acc_sat;
            end else begin
               acc_fw_ff    <= best_fw_ff;
               acc_sw_ff    <= best_sw_ff;
               acc_val_ff   <= best_val_ff;
               acc_valid_ff <= 1'b1;
            end
         end
         if (cmd.flush) begin
            acc_valid_ff <= 1'b0;
            done_ff      <= 1'b1;
         end
         if (cmd.out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_emit        = out_emit_ff;
   assign rsp_first_word  = out_fw_ff;
   assign rsp_second_word = out_sw_ff;
   assign rsp_value       = out_val_ff;
   assign rsp_next_source = out_next_ff;
   assign rsp_merge_done  = out_done_ff;

endmodule

[hdl/weighted_sorted_stream_merge_top.sv]
// An ignored item goes from decode straight to the result; an item that pops a head runs
// through advance, the head scan and the pop, with insertion and scaling where they apply.
// A new item is taken only once the last one has reached the output register. The scan of
// the head slots reads one slot at a time through the single read port of the slot memory.
// Reset is synchronous and active high; it clears the merge state and loads the
// register defaults. Head slots are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module weighted_sorted_stream_merge_top #(
   parameter int SOURCES    = 2,
   parameter int VALUE_BITS = 48
) (
   input logic  clock,
   input logic  reset,
   wssm_req_if.sink      req_chan,
   wssm_rsp_if.source_mp rsp_chan,
   wssm_csr_if.sink      csr_chan
);

   wssm_pkg::dp_cmd_type    cmd;
   wssm_pkg::dp_status_type status;

   wssm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   wssm_datapath #(
      .SOURCES    (SOURCES),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .in_first_word   (req_chan.first_word),
      .in_second_word  (req_chan.second_word),
      .in_count_value  (req_chan.count_value),
      .in_source       (req_chan.source),
      .in_source_ended (req_chan.source_ended),
      .csr_valid       (csr_chan.valid),
      .csr_ready       (csr_chan.ready),
      .csr_index       (csr_chan.index),
      .csr_data        (csr_chan.data),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_emit        (rsp_chan.emit),
      .rsp_first_word  (rsp_chan.out_first_word),
      .rsp_second_word (rsp_chan.out_second_word),
      .rsp_value       (rsp_chan.out_value),
      .rsp_next_source (rsp_chan.next_source),
      .rsp_merge_done  (rsp_chan.merge_done)
   );

endmodule

[hdl/wssm_checker.sv]
// Port-level checker for the merge top level, attached with a bind statement.
// Depends on wssm_pkg and the top level's channel interfaces.
`timescale 1ns / 1ps

module wssm_checker #(
   parameter int VALUE_BITS = 48
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic                              rsp_emit,
   input logic [wssm_pkg::WORD_BITS-1:0]    rsp_first_word,
   input logic [wssm_pkg::WORD_BITS-1:0]    rsp_second_word,
   input logic [VALUE_BITS-1:0]             rsp_value,
   input logic [wssm_pkg::SRC_BITS-1:0]     rsp_next_source,
   input logic                              rsp_merge_done
);

   logic [2:0] pending_ff, pending_in;
   logic       done_seen_ff;
   logic       req_xfer, rsp_xfer;

   assign req_xfer   = req_valid && req_ready;
   assign rsp_xfer   = rsp_valid && rsp_ready;
   assign pending_in = pending_ff + 3'(req_xfer) - 3'(rsp_xfer);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         done_seen_ff <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         if (rsp_xfer && rsp_merge_done) begin
            done_seen_ff <= 1'b1;
         end
      end
   end

   // Every item gives one result; at most one in work and one waiting.
   a_outstanding : assert property (@(posedge clock) disable iff (reset)
      (pending_ff < 3'd3) && (!rsp_valid || (pending_ff != 3'd0)))
      else $error("result count does not follow accepted items");

   // Once the merge has finished, every later result repeats the finished form.
   a_done_sticky : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && done_seen_ff) |->
         (rsp_merge_done && !rsp_emit && (rsp_next_source == '0)))
      else $error("result after merge completion is not a finished result");

   // No result is shown in the cycle after reset.
   a_reset_clear : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result holds.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_emit) && $stable(rsp_first_word) &&
          $stable(rsp_second_word) && $stable(rsp_value) &&
          $stable(rsp_next_source) && $stable(rsp_merge_done)))
      else $error("stalled result changed");

endmodule

bind weighted_sorted_stream_merge_top wssm_checker #(
   .VALUE_BITS (VALUE_BITS)
) u_wssm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_emit        (rsp_chan.emit),
   .rsp_first_word  (rsp_chan.out_first_word),
   .rsp_second_word (rsp_chan.out_second_word),
   .rsp_value       (rsp_chan.out_value),
   .rsp_next_source (rsp_chan.next_source),
   .rsp_merge_done  (rsp_chan.merge_done)
);
